// File: sv/esm_pkg.sv
// ----------------------------------------------------------------------------
// esm_pkg
// shared constants, types and register codes of the escape sequence matcher
// ----------------------------------------------------------------------------
`default_nettype none

package esm_pkg;

    localparam int NUM_CODES    = 6;
    localparam int SLOT_COUNT   = 6;
    localparam int MAX_CODE_LEN = 7;

    localparam int HC_W       = $clog2(MAX_CODE_LEN + 1);
    localparam int POS_COUNT  = MAX_CODE_LEN + 2;
    localparam int POS_W      = $clog2(POS_COUNT);
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] ESC_RESET = 8'd27;

    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT0  = 3'd1;

    localparam logic [POS_W-1:0] POS_HEAD = '0;
    localparam logic [POS_W-1:0] POS_TAIL = POS_W'(POS_COUNT - 1);

    // one request worth of results: head, held bytes, trailing escape
    typedef struct packed {
        logic [POS_COUNT-1:0]            mask;
        logic                            head_code;
        logic [CODE_W-1:0]               code;
        logic [7:0]                      esc;
        logic [MAX_CODE_LEN-1:0][7:0]    bytes;
    } t_desc;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

// File: sv/escape_sequence_matcher.sv
// ----------------------------------------------------------------------------
// escape_sequence_matcher
// byte stream escape code recognizer with decoupled classifier and serializer
// ----------------------------------------------------------------------------
// results of a byte pass the request queue, then the output register
// throughput: one byte per cycle while i_stall low, at most one result a byte
// a byte with k results holds the serializer, one result a cycle if unstalled
// reset: sequence state cleared, escape byte 27, all code slots disabled
// reset: request queue and output register empty
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_matcher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [7:0]                       i_in_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_out_kind,
    output logic [7:0]                       o_out_data,
    output logic [esm_pkg::CODE_W-1:0]       o_out_code,
    output logic                             o_out_last,
    input  logic                             i_cfg_we,
    input  logic [esm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [esm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import esm_pkg::*;

    t_q_stat  q_stat;
    t_desc    push_desc;
    t_desc    head_desc;
    logic     push;
    logic     pop;

    esm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    esm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_desc  (head_desc)
    );

    esm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_stat.valid),
        .i_desc     (head_desc),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_kind (o_out_kind),
        .o_out_data (o_out_data),
        .o_out_code (o_out_code),
        .o_out_last (o_out_last)
    );

endmodule

`default_nettype wire

// File: sv/esm_front.sv
// ----------------------------------------------------------------------------
// esm_front
// accepts bytes, holds sequence state and code table, classifies each byte
// ----------------------------------------------------------------------------
`default_nettype none

module esm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_in_data,
    input  logic                               i_cfg_we,
    input  logic [esm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [esm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  esm_pkg::t_q_stat                   i_q_stat,
    output logic                               o_push,
    output esm_pkg::t_desc                     o_desc
);
    import esm_pkg::*;

    logic [7:0]            r_esc;
    logic [63:0]           r_slot [SLOT_COUNT];
    logic                  r_active, n_active;
    logic [HC_W-1:0]       r_hc, n_hc;
    logic [7:0]            r_held [MAX_CODE_LEN];

    logic                  accept;
    logic                  is_esc;
    logic                  any_en;
    logic [HC_W-1:0]       slot_len [NUM_CODES];
    logic [NUM_CODES-1:0]  slot_ok;
    logic [HC_W-1:0]       wr_idx;
    logic [HC_W-1:0]       n_cnt;
    logic [7:0]            h_new [MAX_CODE_LEN];
    logic                  hit;
    logic [CODE_W-1:0]     sel;
    logic [HC_W-1:0]       sel_len;
    logic                  full;

    function automatic logic [MAX_CODE_LEN-1:0] range_mask(
        input logic [HC_W-1:0] lo,
        input logic [HC_W-1:0] hi
    );
        logic [MAX_CODE_LEN-1:0] m;
        for (int j = 0; j < MAX_CODE_LEN; j++) begin
            m[j] = (HC_W'(j) >= lo) && (HC_W'(j) < hi);
        end
        return m;
    endfunction

    assign accept  = i_valid && !i_q_stat.full;
    assign o_stall = i_q_stat.full;
    assign is_esc  = (i_in_data == r_esc);

    assign wr_idx = (r_hc >= HC_W'(MAX_CODE_LEN)) ? HC_W'(MAX_CODE_LEN - 1) : r_hc;
    assign n_cnt  = wr_idx + HC_W'(1);

    // slot lengths and parallel compare against held bytes plus new byte
    always_comb begin
        any_en = 1'b0;
        for (int j = 0; j < MAX_CODE_LEN; j++) begin
            h_new[j] = (HC_W'(j) == wr_idx) ? i_in_data : r_held[j];
        end
        for (int s = 0; s < NUM_CODES; s++) begin
            slot_len[s] = (r_slot[s][7:0] > 8'(MAX_CODE_LEN)) ? HC_W'(MAX_CODE_LEN)
                                                               : r_slot[s][HC_W-1:0];
            any_en      = any_en || (slot_len[s] != '0);
            slot_ok[s]  = (slot_len[s] != '0);
            for (int j = 0; j < MAX_CODE_LEN; j++) begin
                if ((HC_W'(j) < n_cnt) && (HC_W'(j) < slot_len[s]) &&
                    (h_new[j] != r_slot[s][8*(j+1) +: 8])) begin
                    slot_ok[s] = 1'b0;
                end
            end
        end
    end

    // first slot in table order that does not mismatch
    always_comb begin
        hit     = 1'b0;
        sel     = '0;
        sel_len = '0;
        for (int s = NUM_CODES - 1; s >= 0; s--) begin
            if (slot_ok[s]) begin
                hit     = 1'b1;
                sel     = CODE_W'(s);
                sel_len = slot_len[s];
            end
        end
    end

    assign full = (n_cnt >= sel_len);

    always_comb begin
        n_active         = r_active;
        n_hc             = r_hc;
        o_push           = 1'b0;
        o_desc.mask      = '0;
        o_desc.head_code = 1'b0;
        o_desc.code      = '0;
        o_desc.esc       = r_esc;
        for (int j = 0; j < MAX_CODE_LEN; j++) begin
            o_desc.bytes[j] = r_held[j];
        end
        if (accept) begin
            if (!r_active) begin
                if (!is_esc) begin
                    o_desc.bytes[0] = i_in_data;
                    o_desc.mask[1]  = 1'b1;
                    o_push          = 1'b1;
                end else if (any_en) begin
                    n_active = 1'b1;
                    n_hc     = '0;
                end else begin
                    o_desc.mask[POS_HEAD] = 1'b1;
                    o_push                = 1'b1;
                end
            end else if (is_esc) begin
                // escape inside a sequence: flush, then reopen if any code is enabled, else pass the new escape through
                o_desc.mask = {!any_en, range_mask('0, r_hc), 1'b1};
                o_push      = 1'b1;
                n_hc        = '0;
                n_active    = any_en;
            end else begin
                for (int j = 0; j < MAX_CODE_LEN; j++) begin
                    o_desc.bytes[j] = h_new[j];
                end
                if (hit && !full) begin
                    n_hc = n_cnt;
                end else if (hit) begin
                    o_desc.head_code = 1'b1;
                    o_desc.code      = sel;
                    o_desc.mask      = {1'b0, range_mask(sel_len, n_cnt), 1'b1};
                    o_push           = 1'b1;
                    n_active         = 1'b0;
                    n_hc             = '0;
                end else begin
                    o_desc.mask = {1'b0, range_mask('0, n_cnt), 1'b1};
                    o_push      = 1'b1;
                    n_active    = 1'b0;
                    n_hc        = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_hc     <= '0;
            r_esc    <= ESC_RESET;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_slot[s] <= '0;
            end
        end else begin
            r_active <= n_active;
            r_hc     <= n_hc;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ESCAPE) begin
                    r_esc <= i_cfg_data[7:0];
                end
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    if (i_cfg_index == REG_SLOT0 + CFG_IDX_W'(s)) begin
                        r_slot[s] <= i_cfg_data;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_active && !is_esc) begin
            r_held[wr_idx] <= i_in_data;
        end
    end

`ifndef SYNTHESIS
    a_hc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc < HC_W'(MAX_CODE_LEN))
        else $error("held count out of range");
`endif

endmodule

`default_nettype wire

// File: sv/esm_queue.sv
// ----------------------------------------------------------------------------
// esm_queue
// short request queue between classifier and result serializer
// ----------------------------------------------------------------------------
`default_nettype none

module esm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  esm_pkg::t_desc     i_desc,
    input  logic               i_pop,
    output esm_pkg::t_q_stat   o_stat,
    output esm_pkg::t_desc     o_desc
);
    import esm_pkg::*;

    t_desc                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wp;
    logic [Q_PTR_W-1:0]   r_rp;
    logic [Q_CNT_W-1:0]   r_cnt;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_desc       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: sv/esm_back.sv
// ----------------------------------------------------------------------------
// esm_back
// serializes queued requests into results, one per cycle while not stalled, into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module esm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  esm_pkg::t_desc                i_desc,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_out_kind,
    output logic [7:0]                    o_out_data,
    output logic [esm_pkg::CODE_W-1:0]    o_out_code,
    output logic                          o_out_last
);
    import esm_pkg::*;

    logic                    r_valid;
    logic [POS_COUNT-1:0]    r_done;
    logic                    r_kind;
    logic [7:0]              r_data;
    logic [CODE_W-1:0]       r_code;
    logic                    r_last;

    logic [POS_COUNT-1:0]    rem;
    logic [POS_W-1:0]        pos;
    logic [POS_W-1:0]        pos_m1;
    logic [POS_COUNT-1:0]    sel_bit;
    logic                    last;
    logic                    load;
    logic                    e_kind;
    logic [7:0]              e_data;
    logic [CODE_W-1:0]       e_code;

    assign rem = i_desc.mask & ~r_done;

    // lowest pending result position
    always_comb begin
        pos = POS_HEAD;
        for (int i = POS_COUNT - 1; i >= 0; i--) begin
            if (rem[i]) begin
                pos = POS_W'(i);
            end
        end
    end

    assign pos_m1  = pos - POS_W'(1);
    assign sel_bit = {{(POS_COUNT-1){1'b0}}, 1'b1} << pos;
    assign last    = ((rem & ~sel_bit) == '0);
    assign load    = i_q_valid && (!r_valid || !i_stall);
    assign o_pop   = load && last;

    always_comb begin
        e_kind = 1'b0;
        e_data = '0;
        e_code = '0;
        if (pos == POS_HEAD) begin
            e_kind = i_desc.head_code;
            e_data = i_desc.head_code ? 8'd0 : i_desc.esc;
            e_code = i_desc.head_code ? i_desc.code : '0;
        end else if (pos == POS_TAIL) begin
            e_data = i_desc.esc;
        end else begin
            e_data = i_desc.bytes[pos_m1[HC_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= last ? '0 : (r_done | sel_bit);
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= e_kind;
            r_data <= e_data;
            r_code <= e_code;
            r_last <= last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_kind = r_kind;
    assign o_out_data = r_data;
    assign o_out_code = r_code;
    assign o_out_last = r_last;

`ifndef SYNTHESIS
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_out_last) |=> o_valid)
        else $error("gap inside a result burst");
    a_code_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_kind) |-> ((o_out_code < CODE_W'(NUM_CODES)) && (o_out_data == 8'd0)))
        else $error("bad code result");
`endif

endmodule

`default_nettype wire

// File: tb/sv/escape_sequence_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_matcher_tb
// self-checking bench for the escape sequence matcher. a byte driver runs off
// a queue of pending bytes and a result monitor off one of predicted results;
// every accepted byte goes through a behavioral copy of the matcher, and each
// delivered result is compared field by field against the oldest predicted
// one. code tables and the escape byte are reloaded between traffic phases,
// some of them while a sequence is half received.
// ----------------------------------------------------------------------------

module escape_sequence_matcher_tb;
    import esm_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 50;
    localparam int IDLE_PCT      = 11;

    localparam logic KIND_PLAIN = 1'b0;
    localparam logic KIND_CODE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data;
        logic [CODE_W-1:0] code;
        logic              last;
    } t_token;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [7:0]            i_in_data   = 8'd0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic                  o_out_kind;
    logic [7:0]            o_out_data;
    logic [CODE_W-1:0]     o_out_code;
    logic                  o_out_last;

    // stimulus and scoreboard
    logic [7:0] byte_q [$];
    t_token     expected_tokens [$];
    int         items_queued = 0;
    int         items_taken  = 0;
    int         errors       = 0;
    int         plain_cnt    = 0;
    int         code_cnt     = 0;
    int         cfg_writes   = 0;
    int         cycle_cnt    = 0;
    logic       steady       = 1'b0;

    // matcher copy
    logic [7:0]            esc_byte;
    logic [CFG_DATA_W-1:0] slot_reg [SLOT_COUNT];
    logic                  in_seq;
    int                    held_n;
    logic [7:0]            held [MAX_CODE_LEN];
    t_token                burst [MAX_CODE_LEN + 2];
    int                    burst_n;

    escape_sequence_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_data   (i_in_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_kind  (o_out_kind),
        .o_out_data  (o_out_data),
        .o_out_code  (o_out_code),
        .o_out_last  (o_out_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int code_len(int s);
        int n;
        n = int'(slot_reg[s][7:0]);
        return (n > MAX_CODE_LEN) ? MAX_CODE_LEN : n;
    endfunction

    function automatic logic [7:0] code_char(int s, int j);
        return slot_reg[s][8*(j+1) +: 8];
    endfunction

    function automatic logic codes_enabled();
        for (int s = 0; s < NUM_CODES; s++) begin
            if (code_len(s) != 0) return 1'b1;
        end
        return 1'b0;
    endfunction

    // first slot that is not a mismatch over n held bytes, -1 if none
    function automatic int deciding_slot(int n, output logic full);
        int  len;
        int  cmp;
        logic ok;
        full = 1'b0;
        for (int s = 0; s < NUM_CODES; s++) begin
            len = code_len(s);
            if (len != 0) begin
                cmp = (n < len) ? n : len;
                ok  = 1'b1;
                for (int j = 0; j < cmp; j++) begin
                    if (held[j] != code_char(s, j)) ok = 1'b0;
                end
                if (ok) begin
                    full = (n >= len);
                    return s;
                end
            end
        end
        return -1;
    endfunction

    task automatic add_token(logic kind, logic [7:0] data, int code);
        burst[burst_n] = '{kind: kind, data: data, code: CODE_W'(code), last: 1'b0};
        burst_n++;
    endtask

    task automatic open_seq();
        if (codes_enabled()) begin
            in_seq = 1'b1;
            held_n = 0;
        end else begin
            add_token(KIND_PLAIN, esc_byte, 0);
        end
    endtask

    task automatic match_byte(logic [7:0] b);
        int     n;
        int     s;
        logic   full;
        t_token tok;
        burst_n = 0;
        if (!in_seq) begin
            if (b == esc_byte) open_seq();
            else add_token(KIND_PLAIN, b, 0);
        end else if (b == esc_byte) begin
            add_token(KIND_PLAIN, esc_byte, 0);
            for (int j = 0; j < held_n; j++) add_token(KIND_PLAIN, held[j], 0);
            in_seq = 1'b0;
            held_n = 0;
            open_seq();
        end else begin
            if (held_n >= MAX_CODE_LEN) held_n = MAX_CODE_LEN - 1;
            held[held_n] = b;
            n = held_n + 1;
            s = deciding_slot(n, full);
            if (s >= 0 && !full) begin
                held_n = n;
            end else if (s >= 0) begin
                // a shorter code may win late, leftover held bytes go out plain
                add_token(KIND_CODE, 8'd0, s);
                for (int j = code_len(s); j < n; j++) add_token(KIND_PLAIN, held[j], 0);
                in_seq = 1'b0;
                held_n = 0;
            end else begin
                add_token(KIND_PLAIN, esc_byte, 0);
                for (int j = 0; j < n; j++) add_token(KIND_PLAIN, held[j], 0);
                in_seq = 1'b0;
                held_n = 0;
            end
        end
        for (int i = 0; i < burst_n; i++) begin
            tok      = burst[i];
            tok.last = (i == burst_n - 1);
            expected_tokens.push_back(tok);
        end
    endtask

    task automatic report_mismatch(string what, int want, int got);
        if (errors < 40)
            $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_cnt, what, want, got);
        errors++;
    endtask

    task automatic check_token();
        t_token want;
        if (expected_tokens.size() == 0) begin
            report_mismatch("result with no request pending, data", 0, o_out_data);
        end else begin
            want = expected_tokens.pop_front();
            if (o_out_kind != want.kind) report_mismatch("kind", want.kind, o_out_kind);
            if (o_out_data != want.data) report_mismatch("data", want.data, o_out_data);
            if (o_out_code != want.code) report_mismatch("code", want.code, o_out_code);
            if (o_out_last != want.last) report_mismatch("last", want.last, o_out_last);
            if (want.kind == KIND_CODE) code_cnt++;
            else plain_cnt++;
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (byte_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_valid   <= 1'b1;
                i_in_data <= byte_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor, prediction happens on request acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
            if (i_valid && !o_stall) begin
                match_byte(i_in_data);
                items_taken++;
            end
            if (o_valid && !i_stall) check_token();
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_tokens.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(logic [7:0] b);
        byte_q.push_back(b);
        items_queued++;
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send(t[i]);
    endtask

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0) return 8'(8'h41 + $urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_code(logic [7:0] len, string t);
        logic [CFG_DATA_W-1:0] v;
        v      = '0;
        v[7:0] = len;
        for (int i = 0; i < t.len() && i < MAX_CODE_LEN; i++) v[8*(i+1) +: 8] = t[i];
        return v;
    endfunction

    // small alphabet so that codes share prefixes
    function automatic logic [CFG_DATA_W-1:0] rand_slot();
        logic [CFG_DATA_W-1:0] v;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) v[7:0] = 8'd0;
        else if (r == 1) v[7:0] = 8'($urandom_range(8, 255));
        else v[7:0] = 8'($urandom_range(1, MAX_CODE_LEN));
        for (int j = 1; j < 8; j++) begin
            if ($urandom_range(0, 7) == 0) v[8*j +: 8] = 8'($urandom_range(0, 255));
            else v[8*j +: 8] = 8'(8'h41 + $urandom_range(0, 2));
        end
        return v;
    endfunction

    task automatic settle();
        do @(negedge i_clk);
        while (items_taken != items_queued || expected_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == REG_ESCAPE) esc_byte = data[7:0];
        else if (idx >= REG_SLOT0 && idx < REG_SLOT0 + SLOT_COUNT) slot_reg[idx - REG_SLOT0] = data;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_random_table(logic [7:0] esc);
        write_reg(REG_ESCAPE, CFG_DATA_W'(esc));
        for (int s = 0; s < SLOT_COUNT; s++) write_reg(CFG_IDX_W'(REG_SLOT0 + s), rand_slot());
    endtask

    task automatic random_traffic(int count);
        int start;
        int s;
        int len;
        int cut;
        int r;
        start = items_queued;
        while (items_queued - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                s   = $urandom_range(0, NUM_CODES - 1);
                len = code_len(s);
                if (len == 0) begin
                    send(noise_byte());
                end else begin
                    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : len;
                    send(esc_byte);
                    for (int j = 0; j < cut; j++) send(code_char(s, j));
                    if (cut < len || $urandom_range(0, 5) == 0) send(noise_byte());
                end
            end else if (r < 85) begin
                send(8'($urandom_range(0, 255)));
            end else begin
                send(esc_byte);
                repeat ($urandom_range(0, 3)) send(noise_byte());
            end
        end
    endtask

    initial begin
        esc_byte = ESC_RESET;
        for (int s = 0; s < SLOT_COUNT; s++) slot_reg[s] = '0;
        in_seq = 1'b0;
        held_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset table: nothing enabled, escape passes through
        send(8'h00);
        send(8'hFF);
        send(ESC_RESET);
        settle();

        write_reg(REG_ESCAPE, CFG_DATA_W'(ESC_RESET));
        write_reg(REG_SLOT0 + 3'd0, pack_code(8'd3, "[1~"));
        write_reg(REG_SLOT0 + 3'd1, pack_code(8'd2, "[A"));
        write_reg(REG_SLOT0 + 3'd2, pack_code(8'd200, "OPQRSTU"));
        write_reg(REG_SLOT0 + 3'd3, pack_code(8'd0, "ZZ"));
        write_reg(REG_SLOT0 + 3'd4, pack_code(8'd1, "x"));
        write_reg(REG_SLOT0 + 3'd5, '1);
        write_reg(REG_NONE, '1);

        send(esc_byte); send_text("[1~");
        send(esc_byte); send_text("[1Z");
        send(esc_byte); send(esc_byte); send_text("x");
        send(esc_byte); send_text("OPQR");
        settle();

        // shorter code appears mid sequence
        write_reg(REG_SLOT0 + 3'd0, pack_code(8'd2, "OP"));
        send_text("S");
        send(esc_byte); send_text("[");
        settle();

        // escape byte changed mid sequence
        write_reg(REG_ESCAPE, CFG_DATA_W'(8'h7E));
        send(esc_byte); send_text("[A");
        settle();

        load_random_table(ESC_RESET);
        random_traffic(PHASE_BYTES);
        settle();

        load_random_table(8'h00);
        write_reg(REG_SLOT0 + 3'd0, '1);
        random_traffic(PHASE_BYTES);
        settle();

        load_random_table(8'hFF);
        steady = 1'b1;
        random_traffic(PHASE_BYTES);
        settle();
        steady = 1'b0;

        write_reg(REG_ESCAPE, CFG_DATA_W'($urandom_range(0, 255)));
        for (int s = 0; s < SLOT_COUNT; s++) write_reg(CFG_IDX_W'(REG_SLOT0 + s), '0);
        random_traffic(PHASE_BYTES);
        settle();

        load_random_table(8'($urandom_range(0, 255)));
        random_traffic(PHASE_BYTES);
        settle();

        $display("run: %0d bytes in, %0d plain bytes and %0d recognized codes out",
                 items_taken, plain_cnt, code_cnt);
        $display("run: %0d register writes across reset, directed and random tables",
                 cfg_writes);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/esm_pkg.sv
sv/esm_front.sv
sv/esm_queue.sv
sv/esm_back.sv
sv/escape_sequence_matcher.sv
tb/sv/escape_sequence_matcher_tb.sv
